>>> sv/dmph_pkg.sv
// Shared types, constants and state codes for the double-modulus prefix hash block.
package dmph_pkg;

  localparam int unsigned LANES       = 2;
  localparam int unsigned RES_W       = 30;
  localparam int unsigned PROD_W      = 2 * RES_W;
  localparam int unsigned MU_W        = 31;
  localparam int unsigned LOW_W       = 32;
  localparam int unsigned LETTER_W    = 7;
  localparam int unsigned POS_W       = 13;
  localparam int unsigned START_LSB   = LETTER_W;
  localparam int unsigned END_LSB     = LETTER_W + POS_W;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned HASH_W      = 62;
  localparam int unsigned OUT_DATA_W  = 64;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_ADDR_W  = 1;
  localparam int unsigned DEF_MAX_LEN = 4096;

  typedef logic [RES_W-1:0]    res_t;
  typedef res_t [LANES-1:0]    lane_res_t;
  typedef logic [MU_W-1:0]     mu_t;
  typedef mu_t [LANES-1:0]     lane_mu_t;
  typedef logic [LETTER_W-1:0] letter_t;

  localparam logic [63:0] MOD_FIRST  = 64'd1000000007;
  localparam logic [63:0] MOD_SECOND = 64'd1000000009;

  // Lane 0 works modulo the first prime, lane 1 modulo the second.
  localparam lane_res_t MOD_P      = {RES_W'(MOD_SECOND), RES_W'(MOD_FIRST)};
  localparam lane_res_t BASE_RESET = {30'd972663749, 30'd911382323};
  localparam lane_res_t ALT_BASE   = {30'd9726637, 30'd9113823};
  localparam lane_res_t POWER_INIT = {LANES{RES_W'(1)}};

  // Barrett factors floor(2^60 / p), worked out at elaboration.
  localparam lane_mu_t MU_P = {MU_W'((64'd1 << PROD_W) / MOD_SECOND),
                               MU_W'((64'd1 << PROD_W) / MOD_FIRST)};

  localparam letter_t LETTER_OFFSET = 7'd96;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_BAD  = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APP_PRE,
    ST_APP_POW,
    ST_QRD,
    ST_QMUL,
    ST_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic wr;
    logic rd_pre;
    logic rd_pow;
  } store_ctl_t;

endpackage

>>> sv/dmph_modmul.sv
// Two-lane modular multiply-add, four-stage Barrett reduction pipeline.
module dmph_modmul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  dmph_pkg::lane_res_t op_a,
  input  dmph_pkg::lane_res_t op_b,
  input  dmph_pkg::letter_t  op_add,
  output logic               out_valid,
  output dmph_pkg::lane_res_t res
);
  import dmph_pkg::*;

  logic [3:0] valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[2:0], in_valid};
    end
  end

  assign out_valid = valid_r[3];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    localparam logic [LOW_W-1:0] ONE_P = LOW_W'(MOD_P[l]);
    localparam logic [LOW_W-1:0] TWO_P = LOW_W'(MOD_P[l]) << 1;

    logic [PROD_W-1:0]   x1_r;
    logic [2*MU_W-1:0]   q2_r;
    logic [LOW_W-1:0]    x2_r;
    logic [LOW_W-1:0]    qp3_r;
    logic [LOW_W-1:0]    x3_r;
    logic [LOW_W-1:0]    diff;
    res_t                r4_r;

    // The true remainder is below 3p < 2^32, so the low 32 bits suffice.
    assign diff = x3_r - qp3_r;

    always_ff @(posedge clk) begin
      x1_r  <= PROD_W'(op_a[l]) * PROD_W'(op_b[l]) + PROD_W'(op_add);
      q2_r  <= (2*MU_W)'(x1_r[PROD_W-1:RES_W-1]) * (2*MU_W)'(MU_P[l]);
      x2_r  <= x1_r[LOW_W-1:0];
      qp3_r <= LOW_W'(q2_r[2*MU_W-1:MU_W]) * ONE_P;
      x3_r  <= x2_r;
      if (diff >= TWO_P) begin
        r4_r <= RES_W'(diff - TWO_P);
      end else if (diff >= ONE_P) begin
        r4_r <= RES_W'(diff - ONE_P);
      end else begin
        r4_r <= RES_W'(diff);
      end
    end

    assign res[l] = r4_r;
  end

endmodule

>>> sv/dmph_store.sv
// Prefix-hash and power tables for both moduli in synchronous memories.
module dmph_store #(
  parameter int unsigned MAX_LEN = dmph_pkg::DEF_MAX_LEN
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dmph_pkg::store_ctl_t           ctl,
  input  logic [$clog2(MAX_LEN + 1)-1:0] wr_addr,
  input  dmph_pkg::lane_res_t            wr_prefix,
  input  dmph_pkg::lane_res_t            wr_power,
  input  logic [$clog2(MAX_LEN + 1)-1:0] rd_pre_addr,
  input  logic [$clog2(MAX_LEN + 1)-1:0] rd_pow_addr,
  output dmph_pkg::lane_res_t            rd_prefix,
  output dmph_pkg::lane_res_t            rd_power
);
  import dmph_pkg::*;

  localparam int unsigned DEPTH = MAX_LEN + 1;

  // Entry zero is never written; it reads as prefix zero and power one.
  logic pre_zero_r;
  logic pow_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_zero_r <= 1'b0;
      pow_zero_r <= 1'b0;
    end else begin
      if (ctl.rd_pre) begin
        pre_zero_r <= (rd_pre_addr == '0);
      end
      if (ctl.rd_pow) begin
        pow_zero_r <= (rd_pow_addr == '0);
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    res_t prefix_mem [DEPTH];
    res_t power_mem  [DEPTH];
    res_t pre_q_r;
    res_t pow_q_r;

    always_ff @(posedge clk) begin
      if (ctl.wr) begin
        prefix_mem[wr_addr] <= wr_prefix[l];
        power_mem[wr_addr]  <= wr_power[l];
      end
      if (ctl.rd_pre) begin
        pre_q_r <= prefix_mem[rd_pre_addr];
      end
      if (ctl.rd_pow) begin
        pow_q_r <= power_mem[rd_pow_addr];
      end
    end

    assign rd_prefix[l] = pre_zero_r ? '0 : pre_q_r;
    assign rd_power[l]  = pow_zero_r ? POWER_INIT[l] : pow_q_r;
  end

endmodule

>>> sv/double_mod_prefix_hash.sv
// Top level of the double-modulus polynomial prefix hash block.
// Append beats extend the stored string by one letter and return the hash of the whole
// string; query beats return the hash of letters start_pos up to end_pos (exclusive), as
// the first residue shifted left 32 bits XOR the second. One item is in flight at a time:
// an append or an in-range query holds the block from accepting its beat until its result
// is loaded, passing through the four-stage Barrett multiply pipeline that both residues share
// per modulus, and a query also through its memory reads. A rejected item (bad range, or an
// append to a full store) goes from idle straight to the done state. A finished result sits
// in an output register, so the next beat is accepted while it waits to be taken. No clearing
// pass runs after reset; the block is ready at once.
module double_mod_prefix_hash #(
  parameter int unsigned MAX_LEN = dmph_pkg::DEF_MAX_LEN
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // letter[6:0], start_pos[19:7], end_pos[32:20], zero fill above
  input  logic [dmph_pkg::IN_DATA_W-1:0]    in_tdata,
  // command[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // hash_value[61:0], zero fill above
  output logic [dmph_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status[1:0]
  output logic [dmph_pkg::STATUS_W-1:0]     out_tuser,
  input  logic                              cfg_we,
  input  logic [dmph_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [dmph_pkg::RES_W-1:0]        cfg_wdata
);
  import dmph_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_LEN + 1);
  localparam int unsigned CMP_W  = (ADDR_W > POS_W) ? ADDR_W : POS_W;

  state_t state_r, state_nxt;

  lane_res_t base_r;
  lane_res_t base_red;
  lane_res_t base_eff;
  lane_res_t pre_tail_r;
  lane_res_t pow_tail_r;
  lane_res_t res0_r;
  lane_res_t res1_r;
  lane_res_t sub_res;
  lane_res_t fin;
  lane_res_t mm_a;
  lane_res_t mm_b;
  lane_res_t mm_res;
  lane_res_t st_rd_prefix;
  lane_res_t st_rd_power;

  logic [ADDR_W-1:0] len_r;
  logic              cmd_r;
  letter_t           val_r;
  logic [POS_W-1:0]  a_r;
  logic [POS_W-1:0]  b_r;
  status_t           status_r;
  status_t           acc_status;
  logic              got_first_r;
  logic              out_valid_r;
  logic [HASH_W-1:0] out_hash_r;
  status_t           out_status_r;

  letter_t           in_letter;
  logic [POS_W-1:0]  in_start;
  logic [POS_W-1:0]  in_end;
  logic              full;
  logic              bad_range;
  logic              accept;
  logic              out_load;
  logic              mm_valid;
  logic              mm_out_valid;
  letter_t           mm_add;
  store_ctl_t        st_ctl;
  logic [ADDR_W-1:0] rd_pre_addr;
  logic [ADDR_W-1:0] rd_pow_addr;
  logic [ADDR_W-1:0] wr_addr;

  assign in_letter = in_tdata[LETTER_W-1:0];
  assign in_start  = in_tdata[START_LSB +: POS_W];
  assign in_end    = in_tdata[END_LSB +: POS_W];

  assign full      = (len_r >= ADDR_W'(MAX_LEN));
  assign bad_range = (CMP_W'(in_start) > CMP_W'(in_end)) || (CMP_W'(in_end) > CMP_W'(len_r));
  assign acc_status = (in_tuser == CMD_APPEND) ? (full ? STATUS_FULL : STATUS_OK)
                                               : (bad_range ? STATUS_BAD : STATUS_OK);
  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    mm_valid  = 1'b0;
    st_ctl    = '0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (acc_status != STATUS_OK) begin
            state_nxt = ST_DONE;
          end else if (in_tuser == CMD_APPEND) begin
            state_nxt = ST_APP_PRE;
          end else begin
            state_nxt = ST_QRD;
          end
        end
      end
      ST_APP_PRE: begin
        mm_valid  = 1'b1;
        state_nxt = ST_APP_POW;
      end
      ST_APP_POW: begin
        mm_valid  = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_QRD: begin
        st_ctl.rd_pre = 1'b1;
        st_ctl.rd_pow = 1'b1;
        state_nxt     = ST_QMUL;
      end
      ST_QMUL: begin
        // Multiply prefix[start] by power[end-start]; fetch prefix[end] meanwhile.
        mm_valid      = 1'b1;
        st_ctl.rd_pre = 1'b1;
        state_nxt     = ST_WAIT;
      end
      ST_WAIT: begin
        if (mm_out_valid && (cmd_r == CMD_QUERY || got_first_r)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          st_ctl.wr = (cmd_r == CMD_APPEND) && (status_r == STATUS_OK);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Memory writes only happen in the done state, after all reads of that item,
  // and the next item starts later, so no forwarding is needed.
  assign rd_pre_addr = (state_r == ST_QRD) ? ADDR_W'(a_r) : ADDR_W'(b_r);
  assign rd_pow_addr = ADDR_W'(b_r - a_r);
  assign wr_addr     = len_r + ADDR_W'(1);
  assign mm_add      = (state_r == ST_APP_PRE) ? val_r : '0;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [RES_W:0] sub_diff;

    assign base_red[l] = (base_r[l] >= MOD_P[l]) ? RES_W'(base_r[l] - MOD_P[l]) : base_r[l];
    assign base_eff[l] = (base_red[l] == '0) ? ALT_BASE[l] : base_red[l];

    assign mm_a[l] = (state_r == ST_APP_PRE) ? pre_tail_r[l] :
                     (state_r == ST_APP_POW) ? pow_tail_r[l] : st_rd_prefix[l];
    assign mm_b[l] = (state_r == ST_QMUL) ? st_rd_power[l] : base_eff[l];

    assign sub_diff   = {1'b0, st_rd_prefix[l]} - {1'b0, res0_r[l]};
    assign sub_res[l] = sub_diff[RES_W] ? RES_W'(sub_diff + {1'b0, MOD_P[l]})
                                        : sub_diff[RES_W-1:0];

    assign fin[l] = (status_r == STATUS_BAD)  ? '0 :
                    (cmd_r == CMD_QUERY)      ? sub_res[l] :
                    (status_r == STATUS_FULL) ? pre_tail_r[l] : res0_r[l];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= BASE_RESET;
      len_r       <= '0;
      pre_tail_r  <= '0;
      pow_tail_r  <= POWER_INIT;
      got_first_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_r[cfg_addr] <= cfg_wdata;
      end
      if (accept) begin
        cmd_r       <= in_tuser;
        val_r       <= in_letter - LETTER_OFFSET;
        a_r         <= in_start;
        b_r         <= in_end;
        status_r    <= acc_status;
        got_first_r <= 1'b0;
      end
      if (state_r == ST_WAIT && mm_out_valid) begin
        if (cmd_r == CMD_APPEND && got_first_r) begin
          res1_r <= mm_res;
        end else begin
          res0_r      <= mm_res;
          got_first_r <= 1'b1;
        end
      end
      if (st_ctl.wr) begin
        len_r      <= wr_addr;
        pre_tail_r <= res0_r;
        pow_tail_r <= res1_r;
      end
      if (out_load) begin
        out_valid_r  <= 1'b1;
        out_hash_r   <= {fin[0], 2'b00, fin[1]};
        out_status_r <= status_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - HASH_W){1'b0}}, out_hash_r};
  assign out_tuser  = out_status_r;

  dmph_modmul u_modmul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mm_valid),
    .op_a      (mm_a),
    .op_b      (mm_b),
    .op_add    (mm_add),
    .out_valid (mm_out_valid),
    .res       (mm_res)
  );

  dmph_store #(
    .MAX_LEN (MAX_LEN)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (st_ctl),
    .wr_addr     (wr_addr),
    .wr_prefix   (res0_r),
    .wr_power    (res1_r),
    .rd_pre_addr (rd_pre_addr),
    .rd_pow_addr (rd_pow_addr),
    .rd_prefix   (st_rd_prefix),
    .rd_power    (st_rd_power)
  );

endmodule

>>> sv/dmph_chk.sv
// Port-level checks for the double-modulus prefix hash block, bound to the top level.
module dmph_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dmph_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [dmph_pkg::STATUS_W-1:0]   out_tuser
);
  import dmph_pkg::*;

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // A rejected range carries a zero hash.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STATUS_BAD |-> out_tdata == '0)
    else $error("bad-range result with nonzero hash");

  // Both residues are 30 bits wide, so the gap and fill bits stay clear.
  a_gap_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:30] == 2'b00 && out_tdata[63:62] == 2'b00)
    else $error("residue overflow into gap bits");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // One item at a time: input is closed in the cycle after a beat is taken.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in flight");

endmodule

bind double_mod_prefix_hash dmph_chk u_chk (.*);

>>> tb/double_mod_prefix_hash_tb.sv
// Self-checking testbench for the double-modulus prefix hash block.
`timescale 1ns / 1ps

module double_mod_prefix_hash_tb;
  import dmph_pkg::*;

  localparam int unsigned     STR_CAP           = 4096;
  localparam longint unsigned PRIME_FIRST       = 64'd1000000007;
  localparam longint unsigned PRIME_SECOND      = 64'd1000000009;
  localparam logic [29:0]     BASE_FIRST_INIT   = 30'd911382323;
  localparam logic [29:0]     BASE_SECOND_INIT  = 30'd972663749;
  localparam longint unsigned SPARE_BASE_FIRST  = 64'd9113823;
  localparam longint unsigned SPARE_BASE_SECOND = 64'd9726637;
  localparam logic [6:0]      LETTER_BIAS       = 7'd96;
  localparam logic            REG_BASE_FIRST    = 1'b0;
  localparam logic            REG_BASE_SECOND   = 1'b1;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASE_ITEMS = 115;

  typedef struct packed {
    logic [61:0] hash_value;
    status_t     status;
  } hash_result_t;

  // Keeps its own copy of the prefix and power tables and the expected result beats.
  class hash_checker;
    logic [29:0]  base_reg [2];
    logic [29:0]  prefix_tab [2][STR_CAP+1];
    logic [29:0]  power_tab [2][STR_CAP+1];
    int unsigned  str_len;
    int unsigned  fail_count;
    hash_result_t expected_hashes [$];

    function new();
      base_reg[0] = BASE_FIRST_INIT;
      base_reg[1] = BASE_SECOND_INIT;
      for (int lane = 0; lane < 2; lane++) begin
        prefix_tab[lane][0] = '0;
        power_tab[lane][0]  = 30'd1;
      end
      str_len    = 0;
      fail_count = 0;
    endfunction

    function void set_base(input logic idx, input logic [29:0] val);
      base_reg[idx] = val;
    endfunction

    function int unsigned pending();
      return expected_hashes.size();
    endfunction

    function longint unsigned lane_modulus(input int lane);
      return (lane == 0) ? PRIME_FIRST : PRIME_SECOND;
    endfunction

    // A base that reduces to zero would make every hash trivial, so a fixed spare is used.
    function longint unsigned active_base(input int lane);
      longint unsigned r;
      r = 64'(base_reg[lane]);
      r = r % lane_modulus(lane);
      if (r == 0) r = (lane == 0) ? SPARE_BASE_FIRST : SPARE_BASE_SECOND;
      return r;
    endfunction

    function logic [61:0] pack_hash(input longint unsigned r1, input longint unsigned r2);
      longint unsigned packed_val;
      packed_val = (r1 << 32) ^ r2;
      return packed_val[61:0];
    endfunction

    function longint unsigned span_residue(input int lane, input int unsigned a,
                                           input int unsigned b);
      longint unsigned m, lead, scale, whole;
      m     = lane_modulus(lane);
      lead  = 64'(prefix_tab[lane][a]);
      scale = 64'(power_tab[lane][b-a]);
      whole = 64'(prefix_tab[lane][b]);
      scale = (lead * scale) % m;
      return (whole + m - scale) % m;
    endfunction

    function void note_item(input logic cmd, input logic [6:0] letter,
                            input logic [12:0] first_pos, input logic [12:0] last_pos);
      hash_result_t    exp;
      logic [6:0]      code;
      longint unsigned m, mult, acc;
      if (cmd == CMD_APPEND) begin
        if (str_len >= STR_CAP) begin
          exp.status = STATUS_FULL;
        end else begin
          code = letter - LETTER_BIAS;
          for (int lane = 0; lane < 2; lane++) begin
            m    = lane_modulus(lane);
            mult = active_base(lane);
            acc  = 64'(prefix_tab[lane][str_len]);
            acc  = (acc * mult + 64'(code)) % m;
            prefix_tab[lane][str_len+1] = acc[29:0];
            acc  = 64'(power_tab[lane][str_len]);
            acc  = (acc * mult) % m;
            power_tab[lane][str_len+1] = acc[29:0];
          end
          str_len++;
          exp.status = STATUS_OK;
        end
        exp.hash_value = pack_hash(64'(prefix_tab[0][str_len]), 64'(prefix_tab[1][str_len]));
      end else if (first_pos > last_pos || last_pos > str_len) begin
        exp.hash_value = '0;
        exp.status     = STATUS_BAD;
      end else begin
        exp.hash_value = pack_hash(span_residue(0, 32'(first_pos), 32'(last_pos)),
                                   span_residue(1, 32'(first_pos), 32'(last_pos)));
        exp.status     = STATUS_OK;
      end
      expected_hashes = {expected_hashes, exp};
    endfunction

    function void check_result(input logic [63:0] tdata, input logic [1:0] tuser);
      hash_result_t exp;
      if (expected_hashes.size() == 0) begin
        $error("result beat with nothing expected: hash_value=%h status=%0d", tdata, tuser);
        fail_count++;
        return;
      end
      exp = expected_hashes.pop_front();
      if (tdata !== {2'b00, exp.hash_value}) begin
        $error("hash_value mismatch: expected %h, actual %h", {2'b00, exp.hash_value}, tdata);
        fail_count++;
      end
      if (tuser !== exp.status) begin
        $error("status mismatch: expected %0d, actual %0d", exp.status, tuser);
        fail_count++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata;
  logic                    in_tuser;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic [STATUS_W-1:0]     out_tuser;
  logic                    cfg_we;
  logic [CFG_ADDR_W-1:0]   cfg_addr;
  logic [RES_W-1:0]        cfg_wdata;

  hash_checker book = new();
  bit          sender_gap_free = 1'b0;
  int unsigned hold_off_cycles = 0;
  int unsigned cycle_count = 0;

  double_mod_prefix_hash dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Valid is left high when the next beat follows with no gap, so it is never dropped
  // and raised again within one time step.
  task automatic send_item(input logic cmd, input logic [6:0] letter,
                           input logic [12:0] first_pos, input logic [12:0] last_pos);
    int unsigned gap;
    gap = sender_gap_free ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'b0, last_pos, first_pos, letter};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    book.note_item(cmd, letter, first_pos, last_pos);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  task automatic write_bases(input logic [29:0] first_val, input logic [29:0] second_val);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_BASE_FIRST;
    cfg_wdata <= first_val;
    @(posedge clk);
    book.set_base(REG_BASE_FIRST, first_val);
    cfg_addr  <= REG_BASE_SECOND;
    cfg_wdata <= second_val;
    @(posedge clk);
    book.set_base(REG_BASE_SECOND, second_val);
    cfg_we    <= 1'b0;
  endtask

  // Most queries ask for ranges inside the stored string; the rest are raw 13-bit noise.
  task automatic random_item(input int unsigned append_pct);
    int unsigned roll, len, hi, span;
    logic        cmd;
    logic [6:0]  letter;
    logic [12:0] first_pos, last_pos;
    roll      = $urandom_range(0, 99);
    len       = book.str_len;
    letter    = 7'($urandom_range(97, 122));
    first_pos = 13'($urandom_range(0, 8191));
    last_pos  = 13'($urandom_range(0, 8191));
    if (roll < append_pct) begin
      cmd = CMD_APPEND;
      if ($urandom_range(0, 15) == 0) letter = 7'($urandom_range(0, 127));
    end else begin
      cmd = CMD_QUERY;
      if ($urandom_range(0, 4) != 0) begin
        hi = $urandom_range(0, len);
        if ($urandom_range(0, 1) == 0) span = $urandom_range(0, hi);
        else span = $urandom_range(0, (hi < 6) ? hi : 6);
        last_pos  = 13'(hi);
        first_pos = 13'(hi - span);
      end
    end
    send_item(cmd, letter, first_pos, last_pos);
  endtask

  task automatic run_phase(input int unsigned items, input int unsigned append_pct);
    for (int i = 0; i < items; i++) begin
      if (i % 32 == 0) sender_gap_free = ($urandom_range(0, 3) == 0);
      random_item(append_pct);
    end
    settle();
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty string, letter extremes including ones that wrap, and range edge cases.
    send_item(CMD_QUERY, 7'd0, 13'd0, 13'd0);
    send_item(CMD_QUERY, 7'd0, 13'd0, 13'd1);
    send_item(CMD_APPEND, 7'd97, 13'd0, 13'd0);
    send_item(CMD_APPEND, 7'd122, 13'd0, 13'd0);
    send_item(CMD_APPEND, 7'd96, 13'd0, 13'd0);
    send_item(CMD_APPEND, 7'd0, 13'd0, 13'd0);
    send_item(CMD_APPEND, 7'd127, 13'h1FFF, 13'h1FFF);
    send_item(CMD_QUERY, 7'd0, 13'd0, 13'd5);
    send_item(CMD_QUERY, 7'd0, 13'd1, 13'd3);
    send_item(CMD_QUERY, 7'd0, 13'd5, 13'd5);
    send_item(CMD_QUERY, 7'd0, 13'd3, 13'd2);
    send_item(CMD_QUERY, 7'd0, 13'd0, 13'd6);
    send_item(CMD_QUERY, 7'd127, 13'h1FFF, 13'h1FFF);
    send_item(CMD_QUERY, 7'd0, 13'd0, 13'h1FFF);
    send_item(CMD_QUERY, 7'd0, 13'h1FFF, 13'd0);
    send_item(CMD_QUERY, 7'd0, 13'd4096, 13'd4096);
    send_item(CMD_APPEND, 7'd109, 13'd0, 13'd0);
    send_item(CMD_QUERY, 7'd0, 13'd2, 13'd6);
    settle();

    // Zero bases fall back to the spares; the receiver also holds off here for a while.
    write_bases(30'd0, 30'd0);
    hold_off_cycles = 300;
    run_phase(PHASE_ITEMS, 45);

    write_bases(30'h3FFFFFFF, 30'd1000000009);
    run_phase(PHASE_ITEMS, 45);

    write_bases(30'd1000000006, 30'd1000000008);
    run_phase(PHASE_ITEMS, 45);

    write_bases(30'd1, 30'd1000000007);
    run_phase(PHASE_ITEMS, 45);

    write_bases(30'($urandom), 30'($urandom));
    run_phase(PHASE_ITEMS, 45);

    // Appends with letters 113 and 127, then ranges that reach past the stored string.
    sender_gap_free = 1'b0;
    send_item(CMD_APPEND, 7'd113, 13'd0, 13'd0);
    send_item(CMD_APPEND, 7'd127, 13'd0, 13'd0);
    send_item(CMD_QUERY, 7'd0, 13'd0, 13'd4096);
    send_item(CMD_QUERY, 7'd0, 13'd4095, 13'd4096);
    send_item(CMD_QUERY, 7'd0, 13'd4096, 13'd4096);
    send_item(CMD_QUERY, 7'd0, 13'd2048, 13'd4096);
    send_item(CMD_QUERY, 7'd0, 13'd0, 13'd4097);
    send_item(CMD_QUERY, 7'd0, 13'd4097, 13'd4097);
    settle();

    repeat (20) @(posedge clk);
    if (book.fail_count == 0 && book.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned stall, beat_count;
    bit          sink_gap_free;
    out_tready    = 1'b0;
    beat_count    = 0;
    sink_gap_free = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (beat_count % 40 == 0) sink_gap_free = ($urandom_range(0, 3) == 0);
      stall = sink_gap_free ? 0 : $urandom_range(0, 13);
      if (hold_off_cycles > 0) begin
        stall           = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      book.check_result(out_tdata, out_tuser);
      beat_count++;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule
